// ----- src/mcog_pkg.sv -----
// shared types and constants for the midpoint circle octant generator
// no dependencies; imported by every module of the block
`default_nettype none

package mcog_pkg;

  // field widths fixed by the stream format
  localparam int CoordW      = 15;
  localparam int PixW        = 16;
  localparam int RadiusFieldW = 11;
  localparam int InDataW     = 48;
  localparam int OutDataW    = 32;

  // default radius width
  localparam int RadiusBitsDef = 11;

  // decision update constants
  localparam int DecInit  = 3;
  localparam int DecInc   = 6;
  localparam int DecDec   = 10;

  // pixels emitted per circle point
  localparam int PixPerPoint = 8;
  localparam int PixIdxW     = $clog2(PixPerPoint);

  // operation codes carried on in_tuser
  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_t;

  // one unit of work for the pixel emitter
  typedef struct packed {
    logic signed [CoordW-1:0] cx;
    logic signed [CoordW-1:0] cy;
    logic        [PixW-1:0]   ox;   // x offset, wrapped to pixel width
    logic        [PixW-1:0]   oy;   // y offset, wrapped to pixel width
    logic                     done;
  } job_t;

endpackage

`default_nettype wire

// ----- src/mcog_front.sv -----
// front end: accepts start/step words, runs the midpoint recurrence, issues jobs
// depends on mcog_pkg
`default_nettype none

module mcog_front #(
  parameter int RADIUS_BITS = mcog_pkg::RadiusBitsDef
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_tvalid,
  output logic                             in_tready,
  input  wire  [mcog_pkg::InDataW-1:0]     in_tdata,
  input  wire                              in_tuser,
  output logic                             job_valid,
  input  wire                              job_ready,
  output mcog_pkg::job_t                   job
);
  import mcog_pkg::*;

  localparam int XW   = RADIUS_BITS + 2;
  localparam int DECW = RADIUS_BITS + 7;

  logic signed [XW-1:0]     step_x_r, step_x_nxt;
  logic signed [XW-1:0]     step_y_r, step_y_nxt;
  logic signed [DECW-1:0]   dec_r, dec_nxt;
  logic signed [CoordW-1:0] org_x_r, org_x_nxt;
  logic signed [CoordW-1:0] org_y_r, org_y_nxt;

  logic                     accept;
  logic [PixW-1:0]          rad_wide;
  logic [RADIUS_BITS-1:0]   rad;
  logic signed [DECW-1:0]   rad_dec;
  logic signed [DECW-1:0]   x_dec;
  logic signed [DECW-1:0]   y_dec;
  logic signed [XW-1:0]     y_dn;
  logic signed [XW-1:0]     x_up;
  logic                     finished;

  assign in_tready = job_ready;
  assign job_valid = in_tvalid;
  assign accept    = in_tvalid && in_tready;

  // radius field trimmed or zero-extended to the working width
  assign rad_wide = PixW'(in_tdata[2*CoordW +: RadiusFieldW]);
  assign rad      = rad_wide[RADIUS_BITS-1:0];
  assign rad_dec  = $signed({{(DECW-RADIUS_BITS){1'b0}}, rad});

  assign x_dec    = $signed({{(DECW-XW){step_x_r[XW-1]}}, step_x_r});
  assign y_dec    = $signed({{(DECW-XW){step_y_r[XW-1]}}, step_y_r});
  assign y_dn     = step_y_r - XW'(1);
  assign x_up     = step_x_r + XW'(1);
  assign finished = step_x_r > step_y_r;

  // next state and job for the accepted word
  always_comb begin
    step_x_nxt = step_x_r;
    step_y_nxt = step_y_r;
    dec_nxt    = dec_r;
    org_x_nxt  = org_x_r;
    org_y_nxt  = org_y_r;
    if (op_t'(in_tuser) == OP_START) begin
      org_x_nxt  = $signed(in_tdata[CoordW-1:0]);
      org_y_nxt  = $signed(in_tdata[2*CoordW-1:CoordW]);
      step_x_nxt = '0;
      step_y_nxt = $signed({2'b00, rad});
      dec_nxt    = DECW'(DecInit) - (rad_dec <<< 1);
    end else if (!finished) begin
      if (dec_r[DECW-1]) begin
        dec_nxt = dec_r + (x_dec <<< 2) + DECW'(DecInc);
      end else begin
        step_y_nxt = y_dn;
        // 4*(x - (y-1)) + 10 = 4*(x - y) + 14
        dec_nxt    = dec_r + ((x_dec - y_dec) <<< 2) + DECW'(DecDec + 4);
      end
      step_x_nxt = x_up;
    end
  end

  // job handed to the emitter, built from the updated point
  always_comb begin
    job.cx   = org_x_nxt;
    job.cy   = org_y_nxt;
    job.ox   = PixW'(step_x_nxt);
    job.oy   = PixW'(step_y_nxt);
    job.done = (op_t'(in_tuser) == OP_STEP) && (step_x_nxt > step_y_nxt);
  end

  // recurrence state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_x_r <= '0;
      step_y_r <= '0;
      dec_r    <= '0;
      org_x_r  <= '0;
      org_y_r  <= '0;
    end else if (accept) begin
      step_x_r <= step_x_nxt;
      step_y_r <= step_y_nxt;
      dec_r    <= dec_nxt;
      org_x_r  <= org_x_nxt;
      org_y_r  <= org_y_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- src/mcog_queue.sv -----
// two-entry job queue between the front end and the pixel emitter
// depends on mcog_pkg
`default_nettype none

module mcog_queue (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             wr_valid,
  output logic            wr_ready,
  input  mcog_pkg::job_t  wr_job,
  output logic            rd_valid,
  input  wire             rd_ready,
  output mcog_pkg::job_t  rd_job
);
  import mcog_pkg::*;

  localparam int Depth = 2;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  job_t            mem_r [Depth];
  logic [PtrW-1:0] wr_ptr_r;
  logic [PtrW-1:0] rd_ptr_r;
  logic [CntW-1:0] count_r;
  logic            push;
  logic            pop;

  assign wr_ready = count_r != CntW'(Depth);
  assign rd_valid = count_r != '0;
  assign rd_job   = mem_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PtrW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CntW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ----- src/mcog_back.sv -----
// pixel emitter: expands a job into eight mirrored pixels or one done word
// depends on mcog_pkg
`default_nettype none

module mcog_back (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               job_valid,
  output logic                              job_ready,
  input  mcog_pkg::job_t                    job,
  output logic                              out_tvalid,
  input  wire                               out_tready,
  output logic [mcog_pkg::OutDataW-1:0]     out_tdata,
  output logic                              out_tlast,
  output logic                              out_tuser
);
  import mcog_pkg::*;

  job_t               job_r;
  logic               busy_r;
  logic [PixIdxW-1:0] idx_r;

  logic               out_valid_r;
  logic [PixW-1:0]    out_px_r, out_px_nxt;
  logic [PixW-1:0]    out_py_r, out_py_nxt;
  logic               out_last_r, out_last_nxt;
  logic               out_done_r, out_done_nxt;

  logic               can_load;
  logic               fin;
  logic               pop;
  logic [PixW-1:0]    cx_w;
  logic [PixW-1:0]    cy_w;

  assign can_load  = !out_valid_r || out_tready;
  assign fin       = busy_r && can_load &&
                     (job_r.done || idx_r == PixIdxW'(PixPerPoint - 1));
  assign job_ready = !busy_r || fin;
  assign pop       = job_valid && job_ready;

  assign cx_w = {job_r.cx[CoordW-1], job_r.cx};
  assign cy_w = {job_r.cy[CoordW-1], job_r.cy};

  // pixel for the current octant
  always_comb begin
    out_last_nxt = idx_r == PixIdxW'(PixPerPoint - 1);
    out_done_nxt = 1'b0;
    case (idx_r)
      3'd0: begin out_px_nxt = cx_w + job_r.ox; out_py_nxt = cy_w + job_r.oy; end
      3'd1: begin out_px_nxt = cx_w + job_r.oy; out_py_nxt = cy_w + job_r.ox; end
      3'd2: begin out_px_nxt = cx_w - job_r.oy; out_py_nxt = cy_w + job_r.ox; end
      3'd3: begin out_px_nxt = cx_w - job_r.ox; out_py_nxt = cy_w + job_r.oy; end
      3'd4: begin out_px_nxt = cx_w - job_r.ox; out_py_nxt = cy_w - job_r.oy; end
      3'd5: begin out_px_nxt = cx_w - job_r.oy; out_py_nxt = cy_w - job_r.ox; end
      3'd6: begin out_px_nxt = cx_w + job_r.oy; out_py_nxt = cy_w - job_r.ox; end
      default: begin out_px_nxt = cx_w + job_r.ox; out_py_nxt = cy_w - job_r.oy; end
    endcase
    // finished circle gives a single zeroed word
    if (job_r.done) begin
      out_px_nxt   = '0;
      out_py_nxt   = '0;
      out_last_nxt = 1'b1;
      out_done_nxt = 1'b1;
    end
  end

  // job register and octant counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else if (pop) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
    end else if (fin) begin
      busy_r <= 1'b0;
    end else if (busy_r && can_load) begin
      idx_r  <= idx_r + PixIdxW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job_r <= job;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (busy_r && can_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r && can_load) begin
      out_px_r   <= out_px_nxt;
      out_py_r   <= out_py_nxt;
      out_last_r <= out_last_nxt;
      out_done_r <= out_done_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_py_r, out_px_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_done_r;

endmodule

`default_nettype wire

// ----- src/midpoint_circle_octant_generator.sv -----
// midpoint circle rasterizer: front end runs the recurrence, emitter expands pixels
// throughput: a start or step word yields eight words at one per cycle while out_tready
// is high; a finished step yields one word. the single-output emitter sets the rate.
// path: accepted input word -> queue storage -> emitter job register -> output register.
// reset (rst_n low, synchronous) clears the circle state to a zero-radius circle at the
// origin and empties the job queue and the output register.
`default_nettype none

module midpoint_circle_octant_generator #(
  parameter int RADIUS_BITS = mcog_pkg::RadiusBitsDef
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_tvalid,
  output logic                           in_tready,
  input  wire  [mcog_pkg::InDataW-1:0]   in_tdata,   // center_x[14:0], center_y[29:15], radius[40:30]
  input  wire                            in_tuser,   // operation
  output logic                           out_tvalid,
  input  wire                            out_tready,
  output logic [mcog_pkg::OutDataW-1:0]  out_tdata,  // pixel_x[15:0], pixel_y[31:16]
  output logic                           out_tlast,  // last
  output logic                           out_tuser   // done_res
);
  import mcog_pkg::*;

  logic f_valid, f_ready;
  job_t f_job;
  logic b_valid, b_ready;
  job_t b_job;

  // recurrence and classification
  mcog_front #(
    .RADIUS_BITS (RADIUS_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .job_valid (f_valid),
    .job_ready (f_ready),
    .job       (f_job)
  );

  // decoupling queue
  mcog_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_job   (f_job),
    .rd_valid (b_valid),
    .rd_ready (b_ready),
    .rd_job   (b_job)
  );

  // pixel emitter
  mcog_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .job_valid  (b_valid),
    .job_ready  (b_ready),
    .job        (b_job),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire
